// ----- sv/priority_queue_sorted_insert_unit_defines.svh -----
// ----------------------------------------------------------------------------
// priority_queue_sorted_insert_unit_defines
// Assertion macros for the checker of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUE_SORTED_INSERT_UNIT_DEFINES_SVH
`define PRIORITY_QUEUE_SORTED_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PQSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PQSI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pqsi_pkg.sv -----
// ----------------------------------------------------------------------------
// pqsi_pkg
// Types and codes for the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package pqsi_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int FILL_W = 8;
    localparam int STAT_W = 2;

    // Request types
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] item_data;
        logic [PRIO_W-1:0]        item_priority;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] out_data;
        logic [PRIO_W-1:0]        out_priority;
        logic [FILL_W-1:0]        fill_level;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [PRIO_W-1:0]        prio;
    } entry_t;

    // Broadcast command to every cell of the row
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cell_ctl_t;

endpackage

// ----- sv/pqsi_cell.sv -----
// ----------------------------------------------------------------------------
// pqsi_cell
// One slot of the sorted row: holds an entry, compares it with the incoming
// entry, and takes the new entry, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module pqsi_cell (
    input  logic                clk,
    input  pqsi_pkg::cell_ctl_t ctl,
    input  logic                occupied,
    input  logic                left_flag,
    input  pqsi_pkg::entry_t    left_entry,
    input  pqsi_pkg::entry_t    right_entry,
    output logic                flag,
    output pqsi_pkg::entry_t    entry
);
    import pqsi_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // New entry belongs at or before this slot
    assign flag = !occupied || (ctl.item.prio > entry_reg.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.enq && flag)
        begin
            // Insertion point takes the new entry, slots behind it shift right
            entry_next = left_flag ? left_entry : ctl.item;
        end
        else if (ctl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- sv/priority_queue_sorted_insert_unit.sv -----
// Response: registered, presented in the cycle after its request is accepted.
// Throughput: 1 request per cycle while no response is stalled; every cell
// of the row compares and shifts in the same cycle, so the row update is the
// only work per request. Reset: clears the entry count and the response
// valid; cells keep their contents; only slots below the count are ever read.
// ----------------------------------------------------------------------------
// priority_queue_sorted_insert_unit
// Bounded priority queue kept sorted in a row of cells, head in cell zero.
// ----------------------------------------------------------------------------
module priority_queue_sorted_insert_unit #(
    parameter int DEPTH = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pqsi_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pqsi_pkg::rsp_t rsp
);
    import pqsi_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    cell_ctl_t        ctl;

    logic             flag [DEPTH];
    entry_t           cell_entry [DEPTH];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        ctl.item.data = req.item_data;
        ctl.item.prio = req.item_priority;
        ctl.enq       = accept && (req.req_type == REQ_ENQ) && !is_full;
        ctl.deq       = accept && (req.req_type == REQ_DEQ) && !is_empty;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
            logic   left_flag;
            entry_t left_entry;
            entry_t right_entry;

            if (i == 0)
            begin : g_head
                assign left_flag  = 1'b0;
                assign left_entry = ctl.item;
            end
            else
            begin : g_body
                assign left_flag  = flag[i-1];
                assign left_entry = cell_entry[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            pqsi_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (IDX < count_reg),
                .left_flag   (left_flag),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .flag        (flag[i]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.out_data     = '0;
            rsp_next.out_priority = '0;
            if (req.req_type == REQ_ENQ)
            begin
                if (is_full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.status = ST_ENQUEUED;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.status       = ST_DEQUEUED;
                    rsp_next.out_data     = cell_entry[0].data;
                    rsp_next.out_priority = cell_entry[0].prio;
                    count_next            = count_reg - CNT_W'(1);
                end
            end
            rsp_next.fill_level = FILL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the response payload until taken
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- sv/pqsi_checker.sv -----
// ----------------------------------------------------------------------------
// pqsi_checker
// Port-level checks for the sorted-insert priority queue, bound to the top.
// ----------------------------------------------------------------------------
`include "priority_queue_sorted_insert_unit_defines.svh"

module pqsi_checker #(
    parameter int DEPTH = 128
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input pqsi_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input pqsi_pkg::rsp_t rsp
);
    import pqsi_pkg::*;

    localparam logic [FILL_W-1:0] FILL_AT_FULL = FILL_W'(DEPTH);

    `PQSI_ASSERT_NXT(a_req_hold, clk, rst_n,
        req_valid && !req_ready, req_valid && $stable(req),
        "request item dropped or changed while stalled")

    `PQSI_ASSERT_NXT(a_rsp_hold, clk, rst_n,
        rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
        "response dropped or changed while stalled")

    `PQSI_ASSERT_IMP(a_empty_fill, clk, rst_n,
        rsp_valid && rsp.status == ST_EMPTY, rsp.fill_level == '0,
        "empty status with nonzero fill level")

    `PQSI_ASSERT_IMP(a_full_fill, clk, rst_n,
        rsp_valid && rsp.status == ST_FULL, rsp.fill_level == FILL_AT_FULL,
        "full status below capacity")

    `PQSI_ASSERT_IMP(a_zero_payload, clk, rst_n,
        rsp_valid && rsp.status != ST_DEQUEUED,
        rsp.out_data == '0 && rsp.out_priority == '0,
        "payload nonzero without dequeue")

endmodule

bind priority_queue_sorted_insert_unit pqsi_checker #(.DEPTH(DEPTH)) u_pqsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/priority_queue_sorted_insert_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_queue_sorted_insert_unit_test
// Self-checking bench for the sorted-insert priority queue. A directed
// sequence covers the field extremes, equal-priority ordering and dequeue on
// empty. Random traffic then fills the queue to overflow, drains it past empty
// and wanders between the two. The bench keeps its own sorted list of held
// entries, predicts every response and compares each one field by field.
// ----------------------------------------------------------------------------
module priority_queue_sorted_insert_unit_test;

    import pqsi_pkg::*;

    localparam int QUEUE_DEPTH   = 128;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int RSP_LATENCY   = 1;
    localparam int CYCLE_LIMIT   = 200000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    req_t        pending_reqs[$];
    rsp_t        awaited_rsps[$];
    entry_t      held_entries[$];   // descending priority, head first
    int unsigned total_reqs;
    int unsigned sent_count;
    int unsigned gen_fill;          // fill level as seen by the generator
    int unsigned cycle_count;
    int unsigned fail_count;

    priority_queue_sorted_insert_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    function automatic void add_req(logic kind, logic [DATA_W-1:0] data,
                                    logic [PRIO_W-1:0] prio);
        req_t r;
        r.req_type      = kind;
        r.item_data     = data;
        r.item_priority = prio;
        pending_reqs.push_back(r);
        if (kind == REQ_ENQ && gen_fill < QUEUE_DEPTH)
            gen_fill++;
        else if (kind == REQ_DEQ && gen_fill > 0)
            gen_fill--;
    endfunction

    // Favor ties and the ends of the priority range.
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return PRIO_W'($urandom_range(7));
            default: return PRIO_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Idle profile: 0 = sender sparse gaps, receiver heavy stalls;
    // 1 = the reverse; 2 = no gaps at all.
    function automatic int idle_phase();
        if (sent_count < total_reqs / 3)
            return 0;
        else if (sent_count < 2 * total_reqs / 3)
            return 1;
        return 2;
    endfunction

    // Stimulus and end of run
    initial
    begin
        int unsigned random_start;
        int unsigned seg_len;
        int unsigned enq_pct;
        int unsigned mode;

        gen_fill   = 0;
        fail_count = 0;

        // Directed: empty dequeue, extremes, equal-priority order, drain past empty.
        add_req(REQ_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(REQ_ENQ, 32'h7FFF_FFFF, 16'h0000);
        add_req(REQ_ENQ, 32'h8000_0000, 16'hFFFF);
        add_req(REQ_ENQ, 32'hFFFF_FFFF, 16'h8000);
        add_req(REQ_ENQ, 32'h0000_0000, 16'h8000);
        add_req(REQ_ENQ, 32'h0000_0001, 16'h0000);
        add_req(REQ_ENQ, 32'h5555_5555, 16'hFFFF);
        add_req(REQ_ENQ, 32'hAAAA_AAAA, 16'h0001);
        repeat (8)
            add_req(REQ_DEQ, $urandom, pick_prio());

        random_start = pending_reqs.size();

        // Fill to overflow, then drain past empty.
        while (gen_fill < QUEUE_DEPTH)
            add_req(REQ_ENQ, $urandom, pick_prio());
        repeat (4)
            add_req(REQ_ENQ, $urandom, pick_prio());
        while (gen_fill > 0)
            add_req(REQ_DEQ, $urandom, pick_prio());
        repeat (3)
            add_req(REQ_DEQ, $urandom, pick_prio());

        while (pending_reqs.size() - random_start < RANDOM_ITEMS)
        begin
            mode = $urandom_range(3);
            if (mode == 3)
            begin
                while (gen_fill < QUEUE_DEPTH)
                    add_req(REQ_ENQ, $urandom, pick_prio());
                repeat ($urandom_range(1, 3))
                    add_req(REQ_ENQ, $urandom, pick_prio());
            end
            else
            begin
                enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
                seg_len = $urandom_range(40, 200);
                repeat (seg_len)
                    add_req(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ,
                            $urandom, pick_prio());
            end
        end

        total_reqs = pending_reqs.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (RSP_LATENCY + 4) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_reqs.size() != 0 &&
                $urandom_range(99) >= ((idle_phase() == 0) ? 7 :
                                       (idle_phase() == 1) ? 69 : 0))
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                sent_count++;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= $urandom_range(99) >= ((idle_phase() == 0) ? 69 :
                                                (idle_phase() == 1) ? 7 : 0);
    end

    // Predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin : monitor
        rsp_t        want;
        entry_t      fresh;
        int unsigned slot;

        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                want = '0;
                if (req.req_type == REQ_ENQ)
                begin
                    if (held_entries.size() >= QUEUE_DEPTH)
                    begin
                        want.status = ST_FULL;
                    end
                    else
                    begin
                        // Insert behind every entry of equal or higher priority.
                        fresh.data = req.item_data;
                        fresh.prio = req.item_priority;
                        slot = held_entries.size();
                        while (slot > 0 && fresh.prio > held_entries[slot-1].prio)
                            slot--;
                        held_entries.insert(slot, fresh);
                        want.status = ST_ENQUEUED;
                    end
                end
                else if (held_entries.size() == 0)
                begin
                    want.status = ST_EMPTY;
                end
                else
                begin
                    fresh             = held_entries.pop_front();
                    want.status       = ST_DEQUEUED;
                    want.out_data     = fresh.data;
                    want.out_priority = fresh.prio;
                end
                want.fill_level = FILL_W'(held_entries.size());
                awaited_rsps.push_back(want);
            end

            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    $error("response with none outstanding: status %0d data %0d",
                           rsp.status, rsp.out_data);
                    fail_count++;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.out_data !== want.out_data)
                    begin
                        $error("out_data: expected %0d, got %0d",
                               want.out_data, rsp.out_data);
                        fail_count++;
                    end
                    if (rsp.out_priority !== want.out_priority)
                    begin
                        $error("out_priority: expected %0d, got %0d",
                               want.out_priority, rsp.out_priority);
                        fail_count++;
                    end
                    if (rsp.fill_level !== want.fill_level)
                    begin
                        $error("fill_level: expected %0d, got %0d",
                               want.fill_level, rsp.fill_level);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
